// ===== hw/rtl/swm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants of the sliding window minimum
// Register map codes and the control bundle that drives the cell chain.
// ----------------------------------------------------------------------------
package swm_pkg;

  // Width of the window_size register
  localparam int WSIZE_BITS = 7;

  // APB data and address widths
  localparam int PDATA_BITS = 32;
  localparam int PADDR_BITS = 3;

  // Register indexes (word address = byte address / 4)
  typedef enum logic [0:0] {
    REG_WINDOW_SIZE = 1'b0
  } reg_index_t;

  // Control that every cell of the chain sees in the same cycle
  typedef struct packed {
    logic advance;  // an item is taken this cycle
    logic restart;  // the item opens a new stream
  } cell_ctrl_t;

endpackage : swm_pkg
`default_nettype wire

// ===== hw/rtl/swm_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swm_cell: one cell of the running-minimum chain
// Holds the minimum of the last k+1 samples; takes its neighbor's value and
// folds in the broadcast sample on every accepted item.
// ----------------------------------------------------------------------------
module swm_cell import swm_pkg::*; #(
  parameter int SAMPLE_BITS = 32
) (
  input  logic                          clk,
  input  cell_ctrl_t                    ctrl,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic signed [SAMPLE_BITS-1:0] prev_min,
  output logic signed [SAMPLE_BITS-1:0] cell_min
);

  logic signed [SAMPLE_BITS-1:0] cand;
  logic signed [SAMPLE_BITS-1:0] cell_min_next;

  // On restart the neighbor holds stale history: drop it
  assign cand          = ctrl.restart ? sample : prev_min;
  assign cell_min_next = (sample < cand) ? sample : cand;

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      cell_min <= cell_min_next;
    end
  end

endmodule : swm_cell
`default_nettype wire

// ===== hw/rtl/sliding_window_minimum.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_minimum: running minimum over the last window_size samples
// Chain of compare cells with a registered result stage and an APB register.
// ----------------------------------------------------------------------------
// The block takes one signed sample per clock and, once window_size samples
// have arrived since reset or since the last first_of_stream, returns one
// window_min item per sample: the minimum of the last window_size samples,
// including the current one; before that it returns nothing. Throughput is
// one item per cycle, and each result is registered, ready in the cycle
// after its sample is taken: cell k of the chain holds the minimum of the
// last k+1 samples and updates from its neighbor and the new sample in one
// compare, so no item iterates. The result is taken from the cell selected
// by window_size (a WINDOW_MAX-way select into the output register). Input
// is stalled only while a finished result waits to be taken. window_size of
// zero acts as 1, values above WINDOW_MAX as WINDOW_MAX, and a change takes
// effect on the next item. Write window_size only while the block is idle.
// ----------------------------------------------------------------------------
module sliding_window_minimum import swm_pkg::*; #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  // sample channel
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          first_of_stream,
  // result channel
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic signed [SAMPLE_BITS-1:0] window_min,
  // APB configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [PADDR_BITS-1:0]         paddr,
  input  logic [PDATA_BITS-1:0]         pwdata,
  output logic [PDATA_BITS-1:0]         prdata,
  output logic                          pready
);

  // Cells 0..WINDOW_MAX-2 are enough: the widest window folds the sample
  // into the last of them on the way to the output register.
  localparam int NCELLS    = (WINDOW_MAX > 1) ? (WINDOW_MAX - 1) : 1;
  localparam int CIDX_BITS = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int SEEN_BITS = $clog2(WINDOW_MAX + 1);

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [WSIZE_BITS-1:0] window_size;
  logic                  reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_BITS-1:2] == {(PADDR_BITS-2){1'b0}}) &&
                   (reg_index_t'(paddr[2]) == REG_WINDOW_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WSIZE_BITS'(1);
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      window_size <= pwdata[WSIZE_BITS-1:0];
    end
  end

  // Read back the register; anything beyond the list reads as zero
  assign prdata = reg_sel ? PDATA_BITS'(window_size) : '0;

  // Clamp to 1..WINDOW_MAX
  logic [SEEN_BITS-1:0] eff_size;

  always_comb begin
    if (window_size == '0) begin
      eff_size = SEEN_BITS'(1);
    end else if (int'(window_size) > WINDOW_MAX) begin
      eff_size = SEEN_BITS'(WINDOW_MAX);
    end else begin
      eff_size = SEEN_BITS'(window_size);
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: hold input only while a result waits downstream
  // --------------------------------------------------------------------------
  logic       accept;
  cell_ctrl_t ctrl;

  assign sample_stall = result_valid && result_stall;
  assign accept       = sample_valid && !sample_stall;
  assign ctrl.advance = accept;
  assign ctrl.restart = first_of_stream;

  // --------------------------------------------------------------------------
  // Sample count since restart, saturating at WINDOW_MAX
  // --------------------------------------------------------------------------
  logic [SEEN_BITS-1:0] samples_seen;
  logic [SEEN_BITS-1:0] samples_seen_next;

  always_comb begin
    if (first_of_stream) begin
      samples_seen_next = SEEN_BITS'(1);
    end else if (int'(samples_seen) < WINDOW_MAX) begin
      samples_seen_next = samples_seen + SEEN_BITS'(1);
    end else begin
      samples_seen_next = samples_seen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_seen <= '0;
    end else if (accept) begin
      samples_seen <= samples_seen_next;
    end
  end

  // --------------------------------------------------------------------------
  // Cell chain: cell k = min of the last k+1 samples
  // --------------------------------------------------------------------------
  logic signed [SAMPLE_BITS-1:0] cell_min [NCELLS];

  for (genvar k = 0; k < NCELLS; k++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] prev_min;
    if (k == 0) begin : g_head
      assign prev_min = sample;
    end else begin : g_link
      assign prev_min = cell_min[k-1];
    end
    swm_cell #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .sample   (sample),
      .prev_min (prev_min),
      .cell_min (cell_min[k])
    );
  end

  // --------------------------------------------------------------------------
  // Result: fold the new sample into the cell holding the last
  // window_size-1 samples. Before any history exists (window of one, or a
  // restart) the sample alone is the answer.
  // --------------------------------------------------------------------------
  logic [CIDX_BITS-1:0]          tap_idx;
  logic signed [SAMPLE_BITS-1:0] tap_min;
  logic signed [SAMPLE_BITS-1:0] result_next;
  logic                          has_result;

  assign tap_idx     = CIDX_BITS'(int'(eff_size) - 2);
  assign tap_min     = cell_min[tap_idx];
  assign result_next = (first_of_stream || eff_size == SEEN_BITS'(1) ||
                        tap_min > sample) ? sample : tap_min;
  assign has_result  = (samples_seen_next >= eff_size);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= has_result;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_result) begin
      window_min <= result_next;
    end
  end

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  // Restart leaves exactly one sample counted
  a_restart_count: assert property (@(posedge clk) disable iff (rst)
    accept && first_of_stream |=> samples_seen == SEEN_BITS'(1))
    else $error("sample count not reset by first_of_stream");

  // Count never passes the window depth
  a_seen_bound: assert property (@(posedge clk) disable iff (rst)
    int'(samples_seen) <= WINDOW_MAX)
    else $error("sample count beyond window depth");

  // A window of one echoes the sample
  a_unit_window: assert property (@(posedge clk) disable iff (rst)
    accept && eff_size == SEEN_BITS'(1) |=> result_valid && window_min == $past(sample))
    else $error("window of one did not return the sample");

  // No item is taken while a result is held back
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |-> !accept)
    else $error("item accepted over a held result");
`endif

endmodule : sliding_window_minimum
`default_nettype wire
